// ===== src/kmpsfr_pkg.sv =====
// Shared types and constants for the KMP stream find/replace block.
// No dependencies; imported by kmpsfr_ctrl, kmpsfr_dp and kmp_stream_find_replace.
package kmpsfr_pkg;

  localparam int PATTERN_MAX_DEF = 8;
  localparam int REPLACE_MAX_DEF = 8;

  localparam int BYTE_W    = 8;
  localparam int CFG_W     = 64;  // pattern / replacement registers
  localparam int LEN_W     = 4;   // length registers
  localparam int CFG_IDX_W = 2;
  localparam int TOT_W     = 32;  // saturating stream counters
  localparam int BSEL_W    = 3;   // byte select within a 64-bit register

  localparam logic [CFG_IDX_W-1:0] REG_PAT_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REP_BYTES = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REP_LEN   = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic load;        // item accepted this cycle
    logic build_step;  // one step of the failure table build
    logic walk;        // compare / follow one failure link
    logic prefix;      // emit pattern prefix dropped by a failure link
    logic repl;        // emit replacement bytes
    logic flush;       // emit pending prefix, then the status item
    logic finish;      // release the held result with last set
  } kmp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cfg_pat;     // pattern or pattern length written this cycle
    logic build_done;
    logic walk_fail;
    logic hit;
    logic full_match;
    logic prefix_last;
    logic repl_done;
    logic flush_done;
    logic gen_ok;      // a result can be produced this cycle
  } kmp_sts_t;

  typedef struct packed {
    logic [TOT_W-1:0]  output_length;
    logic [TOT_W-1:0]  match_total;
    logic              is_status;
    logic [BYTE_W-1:0] out_byte;
  } kmp_res_t;

  function automatic logic [BYTE_W-1:0] byte_at(input logic [CFG_W-1:0] w,
                                                input logic [BSEL_W-1:0] sel);
    return w[{sel, 3'b000} +: BYTE_W];
  endfunction

endpackage

// ===== src/kmpsfr_dp.sv =====
// Datapath: config registers, failure table, match state, counters, result regs.
// Depends on kmpsfr_pkg; driven by kmpsfr_ctrl commands.
module kmpsfr_dp
  import kmpsfr_pkg::*;
#(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF,
  parameter int REPLACE_MAX = REPLACE_MAX_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic [BYTE_W-1:0]    data_i,
  input  kmp_cmd_t             cmd_i,
  output kmp_sts_t             sts_o,
  input  logic                 m_tready_i,
  output logic                 m_tvalid_o,
  output kmp_res_t             res_o,
  output logic                 last_o
);

  localparam int CNT_MAX = (PATTERN_MAX > REPLACE_MAX) ? PATTERN_MAX : REPLACE_MAX;
  localparam int CNT_W   = $clog2(CNT_MAX + 1);
  localparam int PIDX_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int RIDX_W  = (REPLACE_MAX > 1) ? $clog2(REPLACE_MAX) : 1;

  logic [CFG_W-1:0] pat_q, rep_q;
  logic [LEN_W-1:0] plen_q, rlen_q;

  logic [PIDX_W-1:0] ftab_q [PATTERN_MAX];

  logic [CNT_W-1:0]  q_q, q_d, k_q, k_d, i_q, i_d;
  logic [BYTE_W-1:0] c_q, c_d;
  logic [TOT_W-1:0]  mcnt_q, mcnt_d, ecnt_q, ecnt_d;

  logic              pend_valid_q, pend_valid_d;
  kmp_res_t          pend_q;
  logic              out_valid_q, out_valid_d;
  kmp_res_t          out_q;
  logic              out_last_q;

  logic [CNT_W-1:0]  m_eff, r_eff, rd_idx, k_next, diff;
  logic [PIDX_W-1:0] f_rd;
  logic [BYTE_W-1:0] p_q_byte, p_k_byte, p_i_byte, r_i_byte;
  logic              ft_we;
  logic              out_free, gen_req, gen_en, walk_emit, fin_push, out_load;
  kmp_res_t          gen_res;
  kmp_sts_t          sts;

  // effective lengths: zero pattern length counts as one, both clamp to max
  always_comb begin
    if (plen_q == '0) begin
      m_eff = CNT_W'(1);
    end else if (plen_q > LEN_W'(PATTERN_MAX)) begin
      m_eff = CNT_W'(PATTERN_MAX);
    end else begin
      m_eff = CNT_W'(plen_q);
    end
    if (rlen_q > LEN_W'(REPLACE_MAX)) begin
      r_eff = CNT_W'(REPLACE_MAX);
    end else begin
      r_eff = CNT_W'(rlen_q);
    end
  end

  assign p_q_byte = byte_at(pat_q, BSEL_W'(q_q[PIDX_W-1:0]));
  assign p_k_byte = byte_at(pat_q, BSEL_W'(k_q[PIDX_W-1:0]));
  assign p_i_byte = byte_at(pat_q, BSEL_W'(i_q[PIDX_W-1:0]));
  assign r_i_byte = byte_at(rep_q, BSEL_W'(i_q[RIDX_W-1:0]));

  // single table read port: k-1 while building, q-1 while matching
  assign rd_idx = cmd_i.build_step ? (k_q - CNT_W'(1)) : (q_q - CNT_W'(1));
  assign f_rd   = ftab_q[rd_idx[PIDX_W-1:0]];
  assign k_next = k_q + CNT_W'(p_k_byte == p_i_byte);
  assign diff   = q_q - k_q;

  assign out_free = !out_valid_q || m_tready_i;

  always_comb begin
    sts             = '0;
    sts.cfg_pat     = cfg_we_i && (cfg_idx_i == REG_PAT_BYTES || cfg_idx_i == REG_PAT_LEN);
    sts.build_done  = i_q >= m_eff;
    sts.walk_fail   = (q_q != '0) && (p_q_byte != c_q);
    sts.hit         = p_q_byte == c_q;
    sts.full_match  = sts.hit && ((q_q + CNT_W'(1)) == m_eff);
    sts.prefix_last = (i_q + CNT_W'(1)) == diff;
    sts.repl_done   = i_q >= r_eff;
    sts.flush_done  = i_q >= q_q;
    sts.gen_ok      = !pend_valid_q || out_free;
  end
  assign sts_o = sts;

  // result generation
  assign walk_emit = cmd_i.walk && !sts.walk_fail && !sts.hit;
  assign gen_req   = walk_emit || cmd_i.prefix || (cmd_i.repl && !sts.repl_done) || cmd_i.flush;
  assign gen_en    = gen_req && sts.gen_ok;

  always_comb begin
    gen_res = '0;
    if (walk_emit) begin
      gen_res.out_byte = c_q;
    end else if (cmd_i.repl) begin
      gen_res.out_byte = r_i_byte;
    end else if (cmd_i.flush && sts.flush_done) begin
      gen_res.is_status     = 1'b1;
      gen_res.match_total   = mcnt_q;
      gen_res.output_length = ecnt_q;
    end else begin
      gen_res.out_byte = p_i_byte;
    end
  end

  // match state and counters
  always_comb begin
    q_d    = q_q;
    k_d    = k_q;
    i_d    = i_q;
    c_d    = c_q;
    mcnt_d = mcnt_q;
    ecnt_d = ecnt_q;
    ft_we  = 1'b0;
    if (cmd_i.load) begin
      c_d = data_i;
      i_d = '0;
    end
    if (cmd_i.build_step && !sts.build_done) begin
      if ((k_q != '0) && (p_k_byte != p_i_byte)) begin
        k_d = CNT_W'(f_rd);
      end else begin
        ft_we = 1'b1;
        k_d   = k_next;
        i_d   = i_q + CNT_W'(1);
      end
    end
    if (cmd_i.walk) begin
      if (sts.walk_fail) begin
        k_d = CNT_W'(f_rd);
        i_d = '0;
      end else if (sts.full_match) begin
        q_d = '0;
        i_d = '0;
        if (mcnt_q != '1) mcnt_d = mcnt_q + TOT_W'(1);
      end else if (sts.hit) begin
        q_d = q_q + CNT_W'(1);
      end
    end
    if (cmd_i.prefix && sts.gen_ok) begin
      if (sts.prefix_last) q_d = k_q;
      else                 i_d = i_q + CNT_W'(1);
    end
    if (cmd_i.repl && sts.gen_ok && !sts.repl_done) i_d = i_q + CNT_W'(1);
    if (cmd_i.flush && sts.gen_ok && !sts.flush_done) i_d = i_q + CNT_W'(1);
    if (gen_en) begin
      if (gen_res.is_status) begin
        q_d    = '0;
        mcnt_d = '0;
        ecnt_d = '0;
      end else if (ecnt_q != '1) begin
        ecnt_d = ecnt_q + TOT_W'(1);
      end
    end
    // pattern change starts a new stream and a table build at position 1
    if (sts.cfg_pat) begin
      q_d    = '0;
      k_d    = '0;
      i_d    = CNT_W'(1);
      mcnt_d = '0;
      ecnt_d = '0;
    end
  end

  // one held result so that last can be set on the final one
  assign fin_push = cmd_i.finish && pend_valid_q && out_free;
  assign out_load = (gen_en && pend_valid_q) || fin_push;

  always_comb begin
    pend_valid_d = pend_valid_q;
    if (gen_en)        pend_valid_d = 1'b1;
    else if (fin_push) pend_valid_d = 1'b0;
    out_valid_d = out_valid_q;
    if (out_load)        out_valid_d = 1'b1;
    else if (m_tready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q        <= '0;
      plen_q       <= LEN_W'(1);
      rep_q        <= '0;
      rlen_q       <= '0;
      q_q          <= '0;
      k_q          <= '0;
      i_q          <= '0;
      mcnt_q       <= '0;
      ecnt_q       <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      for (int n = 0; n < PATTERN_MAX; n++) ftab_q[n] <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PAT_BYTES: pat_q  <= cfg_data_i;
          REG_PAT_LEN:   plen_q <= cfg_data_i[LEN_W-1:0];
          REG_REP_BYTES: rep_q  <= cfg_data_i;
          REG_REP_LEN:   rlen_q <= cfg_data_i[LEN_W-1:0];
          default: ;
        endcase
      end
      q_q          <= q_d;
      k_q          <= k_d;
      i_q          <= i_d;
      mcnt_q       <= mcnt_d;
      ecnt_q       <= ecnt_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      if (ft_we) ftab_q[i_q[PIDX_W-1:0]] <= k_next[PIDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    c_q <= c_d;
    if (gen_en) pend_q <= gen_res;
    if (out_load) begin
      out_q      <= pend_q;
      out_last_q <= fin_push;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign res_o      = out_q;
  assign last_o     = out_last_q;

endmodule

// ===== src/kmpsfr_ctrl.sv =====
// Controller state machine: table build, match walk, emission and item finish.
// Depends on kmpsfr_pkg; drives kmpsfr_dp through kmp_cmd_t.
module kmpsfr_ctrl
  import kmpsfr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_tvalid_i,
  input  logic     mode_i,
  output logic     s_tready_o,
  input  kmp_sts_t sts_i,
  output kmp_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_BUILD  = 3'd1;
  localparam logic [2:0] S_WALK   = 3'd2;
  localparam logic [2:0] S_PREFIX = 3'd3;
  localparam logic [2:0] S_REPL   = 3'd4;
  localparam logic [2:0] S_FLUSH  = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign s_tready_o = (state_q == S_IDLE) && !sts_i.cfg_pat;
  assign accept     = s_tvalid_i && s_tready_o;

  always_comb begin
    cmd_o            = '0;
    cmd_o.load       = accept;
    cmd_o.build_step = state_q == S_BUILD;
    cmd_o.walk       = state_q == S_WALK;
    cmd_o.prefix     = state_q == S_PREFIX;
    cmd_o.repl       = state_q == S_REPL;
    cmd_o.flush      = state_q == S_FLUSH;
    cmd_o.finish     = state_q == S_FIN;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (sts_i.cfg_pat)  state_d = S_BUILD;
        else if (accept)    state_d = mode_i ? S_FLUSH : S_WALK;
      end
      S_BUILD: begin
        // a pattern write during the build restarts it
        if (sts_i.build_done && !sts_i.cfg_pat) state_d = S_IDLE;
      end
      S_WALK: begin
        if (sts_i.walk_fail)       state_d = S_PREFIX;
        else if (sts_i.full_match) state_d = S_REPL;
        else if (sts_i.hit)        state_d = S_FIN;
        else if (sts_i.gen_ok)     state_d = S_FIN;
      end
      S_PREFIX: begin
        if (sts_i.gen_ok && sts_i.prefix_last) state_d = S_WALK;
      end
      S_REPL: begin
        if (sts_i.repl_done) state_d = S_FIN;
      end
      S_FLUSH: begin
        if (sts_i.gen_ok && sts_i.flush_done) state_d = S_FIN;
      end
      S_FIN: begin
        if (sts_i.gen_ok) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/kmp_stream_find_replace.sv =====
// Streaming KMP search and replace: top level joining controller and datapath.
// Depends on kmpsfr_pkg, kmpsfr_ctrl and kmpsfr_dp.
//
// Text bytes enter one item at a time (tuser 0) and leave in order, with each
// complete, non-overlapping match of the pattern replaced by the replacement
// bytes; an end-of-stream item (tuser 1) flushes held partial-match bytes and
// ends with a status item (tuser 1) carrying the saturating match count and
// output length, after which a new stream begins. Every result of one input
// item is followed by the next only after that item is finished; tlast marks
// the final result of each input item, and an item can produce no result.
// One item is in work at a time: a data byte walks the match state, following
// failure links and emitting the prefix bytes each link drops, then emits the
// replacement bytes on a full match; an end-of-stream item flushes its held bytes
// and the status item; output backpressure adds to the time in work since each
// result passes through one holding register and the output register.
// Writing the pattern or its length clears the stream and rebuilds the
// failure table, one link step per cycle, with s_axis_tready_o low meanwhile.
module kmp_stream_find_replace
  import kmpsfr_pkg::*;
#(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF,
  parameter int REPLACE_MAX = REPLACE_MAX_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [7:0]           s_axis_tdata_i,   // [7:0] data_byte
  input  logic                 s_axis_tuser_i,   // [0] mode
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [71:0]          m_axis_tdata_o,   // [7:0] out_byte, [39:8] match_total,
                                                 // [71:40] output_length
  output logic                 m_axis_tuser_o,   // [0] is_status
  output logic                 m_axis_tlast_o
);

  kmp_cmd_t cmd;
  kmp_sts_t sts;
  kmp_res_t res;

  kmpsfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .mode_i     (s_axis_tuser_i),
    .s_tready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  kmpsfr_dp #(
    .PATTERN_MAX (PATTERN_MAX),
    .REPLACE_MAX (REPLACE_MAX)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .data_i     (s_axis_tdata_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .m_tready_i (m_axis_tready_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .res_o      (res),
    .last_o     (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {res.output_length, res.match_total, res.out_byte};
  assign m_axis_tuser_o = res.is_status;

`ifndef SYNTHESIS
  // the status item always closes its end-of-stream item
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o)
    else $error("status item without tlast");

  // an accepted item keeps the input closed for at least the next cycle
  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input reopened right after accept");
`endif

endmodule

// ===== tb/sv/kmpsfr_tb_pkg.sv =====
`timescale 1ns / 100ps
// Scoreboard for the KMP stream find/replace testbench: a bit-exact software
// copy of the matcher that queues the predicted output items and checks them.
// Depends on kmpsfr_pkg.
package kmpsfr_tb_pkg;
  import kmpsfr_pkg::*;

  localparam logic MODE_TEXT = 1'b0;
  localparam logic MODE_END  = 1'b1;

  typedef struct {
    logic [BYTE_W-1:0] out_byte;
    logic              is_status;
    logic [TOT_W-1:0]  match_total;
    logic [TOT_W-1:0]  output_length;
    logic              last;
  } out_item_t;

  class kmpsfr_scoreboard;
    logic [CFG_W-1:0]  pat_word;
    logic [CFG_W-1:0]  rep_word;
    logic [LEN_W-1:0]  pat_len_reg;
    logic [LEN_W-1:0]  rep_len_reg;
    logic [BSEL_W-1:0] fail_link [PATTERN_MAX_DEF];
    int unsigned       depth;
    logic [TOT_W-1:0]  hits;
    logic [TOT_W-1:0]  emitted;
    out_item_t         expected_out[$];
    out_item_t         item_out[$];
    int                mismatches;

    function new();
      pat_word    = '0;
      pat_len_reg = 1;
      rep_word    = '0;
      rep_len_reg = '0;
      mismatches  = 0;
      rebuild_links();
      restart_stream();
    endfunction

    function int unsigned pat_len();
      int unsigned m;
      m = pat_len_reg;
      if (m == 0) m = 1;
      if (m > PATTERN_MAX_DEF) m = PATTERN_MAX_DEF;
      return m;
    endfunction

    function int unsigned rep_len();
      int unsigned r;
      r = rep_len_reg;
      if (r > REPLACE_MAX_DEF) r = REPLACE_MAX_DEF;
      return r;
    endfunction

    function logic [BYTE_W-1:0] pat_at(int unsigned k);
      return pat_word[8*(k%8) +: 8];
    endfunction

    // longest proper prefix that is also a suffix, per matched length
    function void rebuild_links();
      int unsigned k;
      int unsigned q;
      k = 0;
      foreach (fail_link[i]) fail_link[i] = '0;
      for (q = 1; q < pat_len(); q++) begin
        while (k > 0 && pat_at(k) != pat_at(q)) k = fail_link[k-1];
        if (pat_at(k) == pat_at(q)) k++;
        fail_link[q] = BSEL_W'(k);
      end
    endfunction

    function void restart_stream();
      depth   = 0;
      hits    = '0;
      emitted = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_PAT_BYTES: begin
          pat_word = val;
          rebuild_links();
          restart_stream();
        end
        REG_PAT_LEN: begin
          pat_len_reg = val[LEN_W-1:0];
          rebuild_links();
          restart_stream();
        end
        REG_REP_BYTES: rep_word = val;
        REG_REP_LEN:   rep_len_reg = val[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function void emit_text(logic [BYTE_W-1:0] b);
      out_item_t r;
      r.out_byte      = b;
      r.is_status     = 1'b0;
      r.match_total   = '0;
      r.output_length = '0;
      r.last          = 1'b0;
      item_out.push_back(r);
      if (emitted != '1) emitted++;
    endfunction

    // predict the output items caused by one accepted input item
    function void note_item(logic mode, logic [BYTE_W-1:0] c);
      int unsigned m;
      int unsigned q;
      int unsigned k;
      int unsigned i;
      out_item_t   r;
      m = pat_len();
      q = depth;
      item_out.delete();
      if (q >= m) q = 0;
      if (mode == MODE_TEXT) begin
        // each failure link drops a prefix that can no longer start a match
        while (q > 0 && pat_at(q) != c) begin
          k = fail_link[(q-1)%8];
          for (i = 0; i < q - k; i++) emit_text(pat_at(i));
          q = k;
        end
        if (pat_at(q) == c) q++;
        else emit_text(c);
        if (q >= m) begin
          if (hits != '1) hits++;
          for (i = 0; i < rep_len(); i++) emit_text(rep_word[8*i +: 8]);
          q = 0;
        end
        depth = q;
      end else begin
        for (i = 0; i < q; i++) emit_text(pat_at(i));
        r.out_byte      = '0;
        r.is_status     = 1'b1;
        r.match_total   = hits;
        r.output_length = emitted;
        r.last          = 1'b0;
        item_out.push_back(r);
        restart_stream();
      end
      if (item_out.size() > 0) begin
        r = item_out.pop_back();
        r.last = 1'b1;
        item_out.push_back(r);
      end
      foreach (item_out[j]) expected_out.push_back(item_out[j]);
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t ERROR: %s", $time, msg);
    endfunction

    function void check_item(logic [BYTE_W-1:0] ob, logic st, logic [TOT_W-1:0] mt,
                             logic [TOT_W-1:0] ol, logic lst);
      out_item_t w;
      if (expected_out.size() == 0) begin
        flag($sformatf({"unexpected output item: byte %02h status %0b total %0d ",
                        "length %0d last %0b"}, ob, st, mt, ol, lst));
        return;
      end
      w = expected_out.pop_front();
      if (w.out_byte !== ob || w.is_status !== st || w.match_total !== mt ||
          w.output_length !== ol || w.last !== lst) begin
        flag($sformatf({"output item: expected byte %02h status %0b total %0d length %0d ",
                        "last %0b, got byte %02h status %0b total %0d length %0d last %0b"},
                       w.out_byte, w.is_status, w.match_total, w.output_length, w.last,
                       ob, st, mt, ol, lst));
      end
    endfunction

    function int unsigned pending();
      return expected_out.size();
    endfunction

    function void leftovers();
      if (expected_out.size() != 0)
        flag($sformatf("%0d expected output items never arrived", expected_out.size()));
    endfunction
  endclass

endpackage

// ===== tb/sv/kmp_stream_find_replace_test.sv =====
`timescale 1ns / 100ps
// Top-level testbench for kmp_stream_find_replace: directed and random text
// streams under varying backpressure, checked against kmpsfr_scoreboard.
// Depends on kmpsfr_pkg, kmpsfr_tb_pkg and the block's RTL.
module kmp_stream_find_replace_test;
  import kmpsfr_pkg::*;
  import kmpsfr_tb_pkg::*;

  localparam int SETTLE_CYCLES = 40;  // block may still be busy on a silent item
  localparam int SUB_PHASES    = 12;
  localparam int BURST_ITEMS   = 28;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [7:0]           in_data;
  logic                 in_mode;
  logic                 out_valid;
  logic                 out_ready;
  logic [71:0]          out_data;
  logic                 out_status;
  logic                 out_last;

  kmpsfr_scoreboard sb;
  int               tx_idle_pct;
  int               rx_idle_pct;
  logic [CFG_W-1:0] gen_pat;   // pattern used to shape the random text
  int unsigned      gen_plen;

  kmp_stream_find_replace dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_data),
    .s_axis_tuser_i  (in_mode),
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_data),
    .m_axis_tuser_o  (out_status),
    .m_axis_tlast_o  (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (out_valid && out_ready)
      sb.check_item(out_data[7:0], out_status, out_data[39:8], out_data[71:40], out_last);
  end

  task automatic send_item(input logic mode, input logic [7:0] data);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mode  <= mode;
    in_data  <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(mode, data);
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // only called with the sender stopped and nothing outstanding
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic new_settings(input int phase);
    logic [7:0]       a;
    logic [7:0]       b;
    logic [CFG_W-1:0] pat;
    logic [LEN_W-1:0] plen;
    logic [LEN_W-1:0] rlen;
    int unsigned      i;
    a = 8'($urandom_range(0, 255));
    b = 8'($urandom_range(0, 255));
    // a mostly two-letter alphabet gives patterns with nontrivial failure links
    for (i = 0; i < 8; i++) begin
      if ($urandom_range(0, 3) == 0) pat[8*i +: 8] = 8'($urandom_range(0, 255));
      else pat[8*i +: 8] = $urandom_range(0, 1) ? a : b;
    end
    if (phase == 0) plen = 4'd8;
    else if (phase == 1) plen = 4'd1;
    else if ($urandom_range(0, 3) == 0) plen = 4'($urandom_range(0, 15));
    else plen = 4'($urandom_range(1, 8));
    if (phase == 0) rlen = 4'd8;
    else if (phase == 1) rlen = 4'd0;
    else if ($urandom_range(0, 3) == 0) rlen = 4'($urandom_range(0, 15));
    else rlen = 4'($urandom_range(0, 8));
    // sometimes keep the pattern so a new replacement lands mid-stream
    if (phase < 2 || $urandom_range(0, 3) != 0) begin
      write_reg(REG_PAT_BYTES, pat);
      write_reg(REG_PAT_LEN, {32'($urandom), 28'($urandom), plen});
      gen_pat  = pat;
      gen_plen = (plen == 0) ? 1 : (plen > 8) ? 8 : plen;
    end
    write_reg(REG_REP_BYTES, {32'($urandom), 32'($urandom)});
    write_reg(REG_REP_LEN, {32'($urandom), 28'($urandom), rlen});
  endtask

  task automatic run_burst(input int unsigned n);
    int unsigned sent;
    int unsigned k;
    int unsigned len;
    int unsigned j;
    logic [7:0]  c;
    bit          paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < n) begin
      if (!paused && sent >= n / 2) begin
        paused = 1'b1;
        hold_until_drained();
      end
      k = $urandom_range(0, 99);
      if (k < 6) begin
        send_item(MODE_END, 8'($urandom_range(0, 255)));
        sent++;
      end else if (k < 60) begin
        // whole pattern or a prefix, last byte sometimes broken
        len = (k < 35) ? gen_plen : $urandom_range(1, gen_plen);
        for (j = 0; j < len; j++) begin
          c = gen_pat[8*j +: 8];
          if (j == len - 1 && $urandom_range(0, 3) == 0) c = 8'($urandom_range(0, 255));
          send_item(MODE_TEXT, c);
        end
        sent += len;
      end else if (k < 85) begin
        j = $urandom_range(0, gen_plen - 1);
        send_item(MODE_TEXT, gen_pat[8*j +: 8]);
        sent++;
      end else begin
        send_item(MODE_TEXT, 8'($urandom_range(0, 255)));
        sent++;
      end
    end
    hold_until_drained();
  endtask

  initial begin
    logic [7:0] text [8];
    int         p;
    sb          = new();
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = REG_PAT_BYTES;
    cfg_data    = '0;
    in_valid    = 1'b0;
    in_data     = '0;
    in_mode     = MODE_TEXT;
    out_ready   = 1'b0;
    tx_idle_pct = 25;
    rx_idle_pct = 51;
    gen_pat     = '0;
    gen_plen    = 1;
    text        = '{8'h41, 8'h42, 8'h41, 8'h42, 8'h41, 8'h42, 8'h41, 8'h41};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: single zero byte pattern, empty replacement
    send_item(MODE_TEXT, 8'h00);
    send_item(MODE_TEXT, 8'hFF);
    send_item(MODE_TEXT, 8'h00);
    send_item(MODE_END, 8'h5A);
    hold_until_drained();

    // "ABAB": a match, then a mismatch that walks two failure links
    write_reg(REG_PAT_BYTES, 64'hFFFF_FFFF_4241_4241);
    write_reg(REG_PAT_LEN, 64'd4);
    write_reg(REG_REP_BYTES, 64'h0123_4567_897A_7978);
    write_reg(REG_REP_LEN, 64'd3);
    foreach (text[i]) send_item(MODE_TEXT, text[i]);
    send_item(MODE_END, 8'hA5);
    hold_until_drained();

    // zero pattern length acts as one, oversized replacement clamps to eight
    write_reg(REG_PAT_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_PAT_LEN, 64'd0);
    write_reg(REG_REP_BYTES, 64'h8001_7F00_FE02_5AA5);
    write_reg(REG_REP_LEN, 64'hF);
    send_item(MODE_TEXT, 8'hFF);
    send_item(MODE_TEXT, 8'h00);
    send_item(MODE_END, 8'h00);
    hold_until_drained();

    // oversized pattern length clamps to eight; end of stream flushes seven
    write_reg(REG_PAT_BYTES, 64'h4141_4141_4141_4141);
    write_reg(REG_PAT_LEN, 64'hF);
    repeat (7) send_item(MODE_TEXT, 8'h41);
    send_item(MODE_END, 8'hFF);
    hold_until_drained();

    for (p = 0; p < SUB_PHASES; p++) begin
      if (p == SUB_PHASES / 3) begin
        tx_idle_pct = 51;
        rx_idle_pct = 25;
      end else if (p == 2 * SUB_PHASES / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      new_settings(p);
      run_burst(BURST_ITEMS);
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    sb.leftovers();
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
